// ===== hdl/t3dh_pkg.sv =====
package t3dh_pkg;

	localparam int IDX_W               = 6;
	localparam int COORD_W             = 16;
	localparam int DIFF_W              = COORD_W + 1;
	localparam int SQ_W                = 2 * COORD_W;
	localparam int SUM_W               = SQ_W + 2;
	localparam int DIST_W              = 17;
	localparam int S_TDATA_W           = 104;
	localparam int M_TDATA_W           = 24;
	localparam int DEFAULT_POINT_COUNT = 64;

	localparam logic [DIST_W-1:0] RESET_DIST = DIST_W'(256);

	// Control that travels alongside the data through the pipeline.
	typedef struct packed {
		logic             vld;
		logic             trig;
		logic             inr;
		logic [IDX_W-1:0] idx;
	} meta_t;

endpackage

// ===== hdl/t3dh_ram.sv =====
module t3dh_ram import t3dh_pkg::*; #(
	parameter int WIDTH = DIST_W,
	parameter int DEPTH = DEFAULT_POINT_COUNT,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/t3dh_isqrt.sv =====
module t3dh_isqrt import t3dh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  meta_t             in_meta,
	input  logic [SUM_W-1:0]  radicand,
	output meta_t             out_meta,
	output logic [DIST_W-1:0] root
);

	// One result bit per stage, most significant first.
	localparam int STEPS = DIST_W;
	localparam int REM_W = DIST_W + 2;

	meta_t             meta_q [0:STEPS-1];
	logic [REM_W-1:0]  rem_q  [0:STEPS-1];
	logic [DIST_W-1:0] root_q [0:STEPS-1];
	logic [SUM_W-1:0]  rad_q  [0:STEPS-2];

	meta_t             meta_in [0:STEPS-1];
	logic [REM_W-1:0]  rem_in  [0:STEPS-1];
	logic [DIST_W-1:0] root_in [0:STEPS-1];
	logic [SUM_W-1:0]  rad_in  [0:STEPS-1];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [REM_W+1:0] shifted;
		logic [REM_W+1:0] cand;
		logic             take;

		if (k == 0) begin : g_first
			assign meta_in[k] = in_meta;
			assign rem_in[k]  = '0;
			assign root_in[k] = '0;
			assign rad_in[k]  = radicand;
		end else begin : g_next
			assign meta_in[k] = meta_q[k-1];
			assign rem_in[k]  = rem_q[k-1];
			assign root_in[k] = root_q[k-1];
			assign rad_in[k]  = rad_q[k-1];
		end

		assign shifted = {rem_in[k], rad_in[k][SUM_W-1 -: 2]};
		assign cand    = (REM_W+2)'({root_in[k], 2'b01});
		assign take    = (shifted >= cand);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				meta_q[k] <= '0;
			end else if (en) begin
				meta_q[k] <= meta_in[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= take ? REM_W'(shifted - cand) : REM_W'(shifted);
				root_q[k] <= {root_in[k][DIST_W-2:0], take};
			end
		end

		if (k < STEPS - 1) begin : g_rad
			always_ff @(posedge clk) begin
				if (en) begin
					rad_q[k] <= {rad_in[k][SUM_W-3:0], 2'b00};
				end
			end
		end
	end

	assign out_meta = meta_q[STEPS-1];
	assign root     = root_q[STEPS-1];

endmodule

// ===== hdl/triggered_3d_distance_hold_unit.sv =====
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  trigger, point index, listener, point
// m_axis    out        m_axis_tvalid / m_axis_tready  point index, held distance
//
// One request is taken per clock cycle unless the pipeline stalls; each result passes
// through three arithmetic stages, seventeen square-root stages and one output register.
// The square-root pipeline retires one root bit per stage.
// Reset clears all pipeline valid flags and the per-entry written flags, so every stored
// distance reads as 1.0 until it is first recomputed; there is no clearing pass.
// When the output register is full and not being taken, the whole pipeline stalls and
// s_axis_tready falls in the same cycle.
module triggered_3d_distance_hold_unit import t3dh_pkg::*; #(
	parameter int POINT_COUNT = DEFAULT_POINT_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// point_index[5:0], loc_x, loc_y, loc_z, pt_x, pt_y, pt_z (16 bits each), 2 zero bits
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// trigger_on
	input  logic [0:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// result_index[5:0], distance[22:6], 1 zero bit
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	localparam int AW = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;

	// Unpacked request fields.
	logic [IDX_W-1:0]          in_idx;
	logic signed [COORD_W-1:0] loc_x, loc_y, loc_z, pt_x, pt_y, pt_z;

	assign in_idx = s_axis_tdata[IDX_W-1:0];
	assign loc_x  = s_axis_tdata[IDX_W+0*COORD_W +: COORD_W];
	assign loc_y  = s_axis_tdata[IDX_W+1*COORD_W +: COORD_W];
	assign loc_z  = s_axis_tdata[IDX_W+2*COORD_W +: COORD_W];
	assign pt_x   = s_axis_tdata[IDX_W+3*COORD_W +: COORD_W];
	assign pt_y   = s_axis_tdata[IDX_W+4*COORD_W +: COORD_W];
	assign pt_z   = s_axis_tdata[IDX_W+5*COORD_W +: COORD_W];

	// The whole pipeline moves together whenever the output register can take a result.
	logic adv;
	logic out_vld_q;

	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;

	// Stage 1: exact coordinate differences.
	meta_t                    meta_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	meta_t                    meta_in;

	always_comb begin
		meta_in.vld  = s_axis_tvalid;
		meta_in.trig = s_axis_tuser[0];
		meta_in.inr  = ({1'b0, in_idx} < (IDX_W+1)'(POINT_COUNT));
		meta_in.idx  = in_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (adv) begin
			meta_s1 <= meta_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= DIFF_W'(pt_x) - DIFF_W'(loc_x);
			dy_s1 <= DIFF_W'(pt_y) - DIFF_W'(loc_y);
			dz_s1 <= DIFF_W'(pt_z) - DIFF_W'(loc_z);
		end
	end

	// Stage 2: squares. Each difference is at most 65535 in magnitude, so every
	// square fits in 32 unsigned bits.
	meta_t                      meta_s2;
	logic [SQ_W-1:0]            sqx_s2, sqy_s2, sqz_s2;
	logic signed [2*DIFF_W-1:0] prod_x, prod_y, prod_z;

	assign prod_x = dx_s1 * dx_s1;
	assign prod_y = dy_s1 * dy_s1;
	assign prod_z = dz_s1 * dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
		end else if (adv) begin
			meta_s2 <= meta_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2 <= prod_x[SQ_W-1:0];
			sqy_s2 <= prod_y[SQ_W-1:0];
			sqz_s2 <= prod_z[SQ_W-1:0];
		end
	end

	// Stage 3: sum of squares, exact in 34 bits.
	meta_t            meta_s3;
	logic [SUM_W-1:0] sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s3 <= '0;
		end else if (adv) begin
			meta_s3 <= meta_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(sqz_s2);
		end
	end

	// Floor square root, one bit per stage.
	meta_t             meta_sq;
	logic [DIST_W-1:0] root_sq;

	t3dh_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_meta  (meta_s3),
		.radicand (sum_s3),
		.out_meta (meta_sq),
		.root     (root_sq)
	);

	// Distance store. An in-range triggered request writes its new root; an in-range
	// holding request reads the entry. Both happen at the same pipeline position, so a read
	// always sees every write from earlier requests and no forwarding is needed.
	logic [AW-1:0]          addr;
	logic                   ram_we;
	logic                   ram_re;
	logic [DIST_W-1:0]      ram_rdata;
	logic [POINT_COUNT-1:0] written_q;

	assign addr   = meta_sq.idx[AW-1:0];
	assign ram_we = adv && meta_sq.vld && meta_sq.inr && meta_sq.trig;
	assign ram_re = adv && meta_sq.vld && meta_sq.inr && !meta_sq.trig;

	t3dh_ram #(
		.WIDTH (DIST_W),
		.DEPTH (POINT_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (root_sq),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// An entry that has never been written has no stored value; its written flag is clear, so it reads as 1.0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (ram_we) begin
			written_q[addr] <= 1'b1;
		end
	end

	// Output register; the read data of the store lines up with it.
	meta_t             out_meta_q;
	logic [DIST_W-1:0] out_root_q;
	logic              out_written_q;
	logic [DIST_W-1:0] out_dist;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			out_meta_q <= '0;
		end else if (adv) begin
			out_vld_q  <= meta_sq.vld;
			out_meta_q <= meta_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_root_q    <= root_sq;
			out_written_q <= written_q[addr];
		end
	end

	always_comb begin
		if (!out_meta_q.inr) begin
			out_dist = '0;
		end else if (out_meta_q.trig) begin
			out_dist = out_root_q;
		end else if (out_written_q) begin
			out_dist = ram_rdata;
		end else begin
			out_dist = RESET_DIST;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = M_TDATA_W'({out_dist, out_meta_q.idx});

endmodule
